// File: hw/rtl/scd_pkg.sv
`timescale 1ns / 1ps

package scd_pkg;

   // word and field widths
   localparam int ELEM_W    = 32;
   localparam int PROD_W    = 64;
   localparam int NUM_LANES = 4;
   localparam int FRAC_W    = 16;
   // quotient bits kept by each divider lane (anything at or above 2^33 saturates)
   localparam int QUO_W     = 33;
   localparam int DIV_STEPS = QUO_W;
   // shift of the numerator in the overflow test: 2^QUO_W / 2^FRAC_W
   localparam int OVF_SH    = QUO_W - FRAC_W;
   // divider depth: one setup stage plus one stage per quotient bit
   localparam int DIV_LAT   = DIV_STEPS + 1;

   localparam int REQ_DATA_W = 8 * ELEM_W;
   localparam int RSP_DATA_W = NUM_LANES * ELEM_W;
   localparam int RSP_USER_W = 2;

   localparam logic [ELEM_W-1:0] ONE_Q16 = 32'h0001_0000;
   localparam logic [ELEM_W-1:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [ELEM_W-1:0] NEG_MIN = 32'h8000_0000;

   localparam logic KIND_INVERT = 1'b0;
   localparam logic KIND_SOLVE  = 1'b1;

   // determinant and numerators in sign/magnitude form
   typedef struct packed {
      logic                             dneg;
      logic [PROD_W-1:0]                dmag;
      logic [NUM_LANES-1:0]             nneg;
      logic [NUM_LANES-1:0][PROD_W-1:0] nmag;
   } front_type;

   // one divider lane result
   typedef struct packed {
      logic             ovf;
      logic             neg;
      logic [QUO_W-1:0] quo;
   } lane_res_type;

endpackage

// File: hw/rtl/solve_2x2_linear_system_core.sv
`timescale 1ns / 1ps
// channel  | dir | handshake             | payload
// req      | in  | req_tvalid/req_tready | tdata: a_r0c0,a_r1c0,a_r0c1,a_r1c1,b_r0c0..b_r1c1
//          |     |                       | tuser: kind
// rsp      | out | rsp_tvalid/rsp_tready | tdata: x_r0c0,x_r1c0,x_r0c1,x_r1c1
//          |     |                       | tuser: singular, saturated
// csr      | in  | csr_wr_en             | csr_wr_data: det_tolerance
//
// One word enters per cycle while the skid register is empty; it passes through two
// multiply/subtract stages, the divider setup and quotient-bit stages, one output register.
// Four divider lanes run side by side, one per result element.
// Synchronous reset empties the pipeline and sets det_tolerance to 1.
// A stalled output parks one word in a skid register; input stalls only while it is full.

module solve_2x2_linear_system_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [scd_pkg::REQ_DATA_W-1:0]    req_tdata,   // a_r0c0,a_r1c0,a_r0c1,a_r1c1,
                                                          // b_r0c0,b_r1c0,b_r0c1,b_r1c1
   input  logic                              req_tuser,   // kind
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [scd_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // x_r0c0,x_r1c0,x_r0c1,x_r1c1
   output logic [scd_pkg::RSP_USER_W-1:0]    rsp_tuser,   // singular, saturated
   input  logic                              csr_wr_en,
   input  logic [scd_pkg::ELEM_W-1:0]        csr_wr_data
);
   import scd_pkg::*;

   logic                                en, busy, front_vld;
   front_type                           front;
   lane_res_type [NUM_LANES-1:0]        lanes;
   logic [ELEM_W-1:0]                   tol_ff;
   logic                                vld_ff  [0:DIV_LAT-1];
   logic                                sing_ff [0:DIV_LAT-1];
   logic                                sing_in;

   assign en         = !busy;
   assign req_tready = en;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= ELEM_W'(1);
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   scd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (req_tvalid),
      .kind    (req_tuser),
      .data    (req_tdata),
      .out_vld (front_vld),
      .out     (front)
   );

   // singular test, carried beside the divider lanes
   assign sing_in = (front.dmag == '0) || (front.dmag < {{(PROD_W-ELEM_W){1'b0}}, tol_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= front_vld;
         for (int k = 1; k < DIV_LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sing_ff[0] <= sing_in;
         for (int k = 1; k < DIV_LAT; k++) sing_ff[k] <= sing_ff[k-1];
      end
   end

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      scd_div_lane u_div (
         .clock (clock),
         .en    (en),
         .neg   (front.nneg[g] ^ front.dneg),
         .num   (front.nmag[g]),
         .den   (front.dmag),
         .res   (lanes[g])
      );
   end

   scd_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .tail_vld   (vld_ff[DIV_LAT-1]),
      .singular   (sing_ff[DIV_LAT-1]),
      .lanes      (lanes),
      .busy       (busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: hw/rtl/scd_front.sv
`timescale 1ns / 1ps

module scd_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_vld,
   input  logic                              kind,
   input  logic [scd_pkg::REQ_DATA_W-1:0]    data,
   output logic                              out_vld,
   output scd_pkg::front_type                out
);
   import scd_pkg::*;

   logic signed [ELEM_W-1:0] a00, a10, a01, a11, b00, b10, b01, b11;
   logic signed [ELEM_W-1:0] ma [0:NUM_LANES];
   logic signed [ELEM_W-1:0] mb [0:NUM_LANES];
   logic signed [ELEM_W-1:0] mc [0:NUM_LANES];
   logic signed [ELEM_W-1:0] md [0:NUM_LANES];
   logic signed [PROD_W-1:0] p_in [0:NUM_LANES];
   logic signed [PROD_W-1:0] q_in [0:NUM_LANES];
   logic signed [PROD_W-1:0] p_ff [0:NUM_LANES];
   logic signed [PROD_W-1:0] q_ff [0:NUM_LANES];
   logic [PROD_W:0]          dif  [0:NUM_LANES];
   logic [PROD_W:0]          mag  [0:NUM_LANES];
   logic                     v1_ff, v2_ff;
   front_type                out_in, out_ff;

   // unpack; inversion uses the identity as right side
   always_comb begin
      a00 = data[0*ELEM_W +: ELEM_W];
      a10 = data[1*ELEM_W +: ELEM_W];
      a01 = data[2*ELEM_W +: ELEM_W];
      a11 = data[3*ELEM_W +: ELEM_W];
      if (kind == KIND_SOLVE) begin
         b00 = data[4*ELEM_W +: ELEM_W];
         b10 = data[5*ELEM_W +: ELEM_W];
         b01 = data[6*ELEM_W +: ELEM_W];
         b11 = data[7*ELEM_W +: ELEM_W];
      end else begin
         b00 = ONE_Q16;
         b10 = '0;
         b01 = '0;
         b11 = ONE_Q16;
      end
      // index 0 is the determinant, 1..4 the numerators of x
      ma[0] = a00; mb[0] = a11; mc[0] = a01; md[0] = a10;
      ma[1] = a11; mb[1] = b00; mc[1] = a01; md[1] = b10;
      ma[2] = a00; mb[2] = b10; mc[2] = a10; md[2] = b00;
      ma[3] = a11; mb[3] = b01; mc[3] = a01; md[3] = b11;
      ma[4] = a00; mb[4] = b11; mc[4] = a10; md[4] = b01;
      for (int i = 0; i <= NUM_LANES; i++) begin
         p_in[i] = ma[i] * mb[i];
         q_in[i] = mc[i] * md[i];
      end
   end

   // exact differences as sign and magnitude
   always_comb begin
      for (int i = 0; i <= NUM_LANES; i++) begin
         dif[i] = {p_ff[i][PROD_W-1], p_ff[i]} - {q_ff[i][PROD_W-1], q_ff[i]};
         mag[i] = dif[i][PROD_W] ? ((PROD_W+1)'(0) - dif[i]) : dif[i];
      end
      out_in.dneg = dif[0][PROD_W];
      out_in.dmag = mag[0][PROD_W-1:0];
      for (int i = 0; i < NUM_LANES; i++) begin
         out_in.nneg[i] = dif[i+1][PROD_W];
         out_in.nmag[i] = mag[i+1][PROD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= NUM_LANES; i++) begin
            p_ff[i] <= p_in[i];
            q_ff[i] <= q_in[i];
         end
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_vld;
         v2_ff <= v1_ff;
      end
   end

   assign out_vld = v2_ff;
   assign out     = out_ff;

endmodule

// File: hw/rtl/scd_div_lane.sv
`timescale 1ns / 1ps

module scd_div_lane (
   input  logic                          clock,
   input  logic                          en,
   input  logic                          neg,
   input  logic [scd_pkg::PROD_W-1:0]    num,
   input  logic [scd_pkg::PROD_W-1:0]    den,
   output scd_pkg::lane_res_type         res
);
   import scd_pkg::*;

   logic [PROD_W-1:0] r_ff   [0:DIV_STEPS];
   logic [PROD_W-1:0] d_ff   [0:DIV_STEPS];
   logic [OVF_SH-1:0] nl_ff  [0:DIV_STEPS];
   logic [QUO_W-1:0]  q_ff   [0:DIV_STEPS];
   logic              ovf_ff [0:DIV_STEPS];
   logic              neg_ff [0:DIV_STEPS];
   logic [PROD_W-1:0] rs     [0:DIV_STEPS-1];
   logic              ge     [0:DIV_STEPS-1];

   // restoring step per stage, one quotient bit each
   always_comb begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         rs[k] = {r_ff[k][PROD_W-2:0], nl_ff[k][OVF_SH-1]};
         ge[k] = (rs[k] >= d_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // setup: quotient of 2^QUO_W or more saturates for sure
         ovf_ff[0] <= ({{OVF_SH{1'b0}}, num} >= {den, {OVF_SH{1'b0}}});
         r_ff[0]   <= num >> OVF_SH;
         nl_ff[0]  <= num[OVF_SH-1:0];
         d_ff[0]   <= den;
         q_ff[0]   <= '0;
         neg_ff[0] <= neg;
         for (int k = 0; k < DIV_STEPS; k++) begin
            r_ff[k+1]   <= ge[k] ? (rs[k] - d_ff[k]) : rs[k];
            q_ff[k+1]   <= {q_ff[k][QUO_W-2:0], ge[k]};
            nl_ff[k+1]  <= {nl_ff[k][OVF_SH-2:0], 1'b0};
            d_ff[k+1]   <= d_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   assign res.ovf = ovf_ff[DIV_STEPS];
   assign res.neg = neg_ff[DIV_STEPS];
   assign res.quo = q_ff[DIV_STEPS];

endmodule

// File: hw/rtl/scd_merge.sv
`timescale 1ns / 1ps

module scd_merge (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                tail_vld,
   input  logic                                                singular,
   input  scd_pkg::lane_res_type [scd_pkg::NUM_LANES-1:0]      lanes,
   output logic                                                busy,
   output logic                                                rsp_tvalid,
   input  logic                                                rsp_tready,
   output logic [scd_pkg::RSP_DATA_W-1:0]                      rsp_tdata,
   output logic [scd_pkg::RSP_USER_W-1:0]                      rsp_tuser
);
   import scd_pkg::*;

   logic [RSP_DATA_W-1:0] data_in, out_data_ff, skid_data_ff;
   logic [RSP_USER_W-1:0] user_in, out_user_ff, skid_user_ff;
   logic [NUM_LANES-1:0]  sat;
   logic                  out_vld_ff, skid_vld_ff;
   logic                  tail_fire;

   // sign, clip and singular masking of each lane
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         if (lanes[i].neg) begin
            sat[i] = lanes[i].ovf || (lanes[i].quo > {1'b0, NEG_MIN});
            data_in[i*ELEM_W +: ELEM_W] = sat[i] ? NEG_MIN :
                                          (ELEM_W'(0) - lanes[i].quo[ELEM_W-1:0]);
         end else begin
            sat[i] = lanes[i].ovf || (lanes[i].quo > {1'b0, POS_MAX});
            data_in[i*ELEM_W +: ELEM_W] = sat[i] ? POS_MAX : lanes[i].quo[ELEM_W-1:0];
         end
      end
      user_in = {(|sat), 1'b0};
      if (singular) begin
         data_in = '0;
         user_in = {1'b0, 1'b1};
      end
   end

   assign busy      = skid_vld_ff;
   assign tail_fire = tail_vld && !skid_vld_ff;

   // output register with skid word behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || rsp_tready) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= tail_fire;
         end
      end else if (tail_fire) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || rsp_tready) begin
         if (skid_vld_ff) begin
            out_data_ff <= skid_data_ff;
            out_user_ff <= skid_user_ff;
         end else begin
            out_data_ff <= data_in;
            out_user_ff <= user_in;
         end
      end else if (tail_fire) begin
         skid_data_ff <= data_in;
         skid_user_ff <= user_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff) else $error("skid word without output word");
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_user_ff[0]) |-> (out_data_ff == '0 && !out_user_ff[1]))
      else $error("singular word carries data or clip flag");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!out_vld_ff && !skid_vld_ff)) else $error("not empty after reset");
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && rsp_tready) |=> !skid_vld_ff) else $error("skid word not drained");

endmodule
